>>> src/aip_pkg.sv
package aip_pkg;

   // one character of a string, with its restart mark and radix request
   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic [5:0] base_request;
   } req_payload_type;

   // one parsed number
   typedef struct packed {
      logic signed [63:0] value;
      logic [11:0]        end_offset;
   } rsp_payload_type;

   localparam int unsigned ValueWidth  = 64;
   localparam int unsigned OffsetWidth = 12;
   localparam int unsigned RadixWidth  = 6;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   localparam logic [RadixWidth-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RadixWidth-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RadixWidth-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RadixWidth-1:0] RADIX_HEX  = 6'd16;

endpackage

>>> src/aip_chan_if.sv
interface aip_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/ascii_integer_parser_core.sv
// channel  | dir | payload                                | handshake
// req_if   | in  | ch[7:0], first, base_request[5:0]      | valid/ready
// rsp_if   | out | value[63:0] signed, end_offset[11:0]   | valid/ready
//
// One character is taken per cycle when not stalled; a terminating character
// is held in the input register, and its result in the result register.
// The 64 x 6 multiply-add on the accumulator sets the path between the two.
// Synchronous reset empties both registers and leaves the parser waiting for
// a first character. A held result stalls the parse only when the next
// character would produce another result; other characters keep flowing.
module ascii_integer_parser_core import aip_pkg::*; #(
   parameter int unsigned OFFSET_LIMIT = 4095
) (
   input  logic       clock,
   input  logic       reset,
   aip_chan_if.sink   req_if,
   aip_chan_if.source rsp_if
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type item_ff;
   logic            emit;
   logic            out_free;
   logic            advance;
   rsp_payload_type result;

   // hold the item only if it ends a number and the result slot is taken
   assign advance      = in_valid_ff && (!emit || out_free);
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         item_ff <= req_if.payload;
      end
   end

   aip_step #(
      .OFFSET_LIMIT(OFFSET_LIMIT)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .emit    (emit),
      .result  (result)
   );

   aip_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && emit),
      .data   (result),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

endmodule

>>> src/aip_step.sv
module aip_step import aip_pkg::*; #(
   parameter int unsigned OFFSET_LIMIT = 4095
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_payload_type item,
   output logic            emit,
   output rsp_payload_type result
);

   localparam int unsigned CountWidth = $clog2(OFFSET_LIMIT + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(OFFSET_LIMIT);

   localparam logic [2:0] PH_DONE   = 3'd0;
   localparam logic [2:0] PH_SPACE  = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   typedef struct packed {
      logic                  ok;
      logic [RadixWidth-1:0] val;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      logic [7:0] t;
      d = '0;
      t = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
         d = '{ok: 1'b1, val: t[RadixWidth-1:0]};
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         t = c - CH_UP_A + 8'd10;
         d = '{ok: 1'b1, val: t[RadixWidth-1:0]};
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         t = c - CH_LO_A + 8'd10;
         d = '{ok: 1'b1, val: t[RadixWidth-1:0]};
      end
      return d;
   endfunction

   logic [2:0]            phase_ff, phase_in, phase_cur;
   logic [ValueWidth-1:0] accum_ff, accum_in, accum_cur;
   logic [RadixWidth-1:0] radix_ff, radix_in, radix_cur, radix_eff;
   logic                  minus_ff, minus_in, minus_cur;
   logic [CountWidth-1:0] count_ff, count_in, count_cur, count_bump;

   logic                                   blank;
   logic                                   to_digits;
   digit_type                              dig;
   logic [ValueWidth+RadixWidth-1:0]       product;
   logic [ValueWidth-1:0]                  accum_next;
   logic [CountWidth+OffsetWidth-1:0]      count_ext;

   always_comb begin
      // a first item restarts the parse before the character is looked at
      if (item.first) begin
         phase_cur = PH_SPACE;
         accum_cur = '0;
         radix_cur = item.base_request;
         minus_cur = 1'b0;
         count_cur = '0;
      end else begin
         phase_cur = phase_ff;
         accum_cur = accum_ff;
         radix_cur = radix_ff;
         minus_cur = minus_ff;
         count_cur = count_ff;
      end
   end

   assign blank      = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
   assign count_bump = (count_cur < CountMax) ? count_cur + 1'b1 : count_cur;
   assign dig        = digit_of(item.ch);

   always_comb begin
      phase_in  = phase_cur;
      accum_in  = accum_cur;
      radix_in  = radix_cur;
      minus_in  = minus_cur;
      count_in  = count_cur;
      radix_eff = radix_cur;
      to_digits = 1'b0;
      emit      = 1'b0;

      if (phase_cur != PH_DONE) begin
         priority if (phase_cur == PH_SPACE && blank) begin
            count_in = count_bump;
         end else if (phase_cur == PH_SPACE && (item.ch == CH_PLUS || item.ch == CH_MINUS)) begin
            minus_in = (item.ch == CH_MINUS);
            count_in = count_bump;
            phase_in = PH_SIGNED;
         end else if (phase_cur == PH_SPACE || phase_cur == PH_SIGNED) begin
            if (item.ch == CH_ZERO && (radix_cur == RADIX_AUTO || radix_cur == RADIX_HEX)) begin
               count_in = count_bump;
               phase_in = PH_ZERO;
            end else begin
               radix_eff = (radix_cur == RADIX_AUTO) ? RADIX_DEC : radix_cur;
               to_digits = 1'b1;
            end
         end else if (phase_cur == PH_ZERO) begin
            if (item.ch == CH_LO_X || item.ch == CH_UP_X) begin
               radix_in = RADIX_HEX;
               count_in = count_bump;
               phase_in = PH_DIGITS;
            end else begin
               radix_eff = (radix_cur == RADIX_AUTO) ? RADIX_OCT : radix_cur;
               to_digits = 1'b1;
            end
         end else begin
            to_digits = 1'b1;
         end
      end

      if (to_digits) begin
         radix_in = radix_eff;
         if (!dig.ok || dig.val >= radix_eff) begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end else begin
            accum_in = accum_next;
            count_in = count_bump;
            phase_in = PH_DIGITS;
         end
      end
   end

   // 64 x 6 multiply-add, wrapping modulo 2^64
   assign product    = accum_cur * radix_eff;
   assign accum_next = product[ValueWidth-1:0] + {{(ValueWidth-RadixWidth){1'b0}}, dig.val};

   assign count_ext         = {{OffsetWidth{1'b0}}, count_cur};
   assign result.value      = minus_cur ? -accum_cur : accum_cur;
   assign result.end_offset = count_ext[OffsetWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         accum_ff <= '0;
         radix_ff <= '0;
         minus_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         radix_ff <= radix_in;
         minus_ff <= minus_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/aip_out_reg.sv
module aip_out_reg import aip_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type data,
   output logic            free,
   aip_chan_if.source      rsp_if
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // the slot can take a new item when empty or being drained this cycle
   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = data_ff;

endmodule
